/* rtl/core/sme_pkg.sv */
// ----------------------------------------------------------------------------
// sme_pkg
// Types and constants for the sysex msb-group encoder.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int unsigned GROUP_SIZE = 7;
  localparam int unsigned POS_W      = 3;
  localparam logic [6:0]  LOW7_MASK  = 7'h7f;
  localparam logic [7:0]  TOP_BIT    = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_byte;
    logic       is_header;
    logic       run_last;
    logic       message_end;
  } out_item_t;

  // one closed group waiting to be sent
  typedef struct packed {
    logic [GROUP_SIZE-1:0][6:0] data;
    logic [6:0]                 top_bits;
    logic [POS_W-1:0]           count;
    logic                       last;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* rtl/core/sme_front.sv */
// ----------------------------------------------------------------------------
// sme_front
// Gathers input bytes into a group and hands closed groups to the queue.
// ----------------------------------------------------------------------------
module sme_front
  import sme_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_item_t      in_data,
  input  queue_status_t q_status,
  output logic          push,
  output group_t        push_group
);

  logic [GROUP_SIZE-1:0][6:0] store_r, store_nxt;
  logic [6:0]                 top_bits_r, top_bits_nxt;
  logic [POS_W-1:0]           fill_count_r, fill_count_nxt;

  logic             accept;
  logic             out_of_range;
  logic [POS_W-1:0] pos;
  logic [6:0]       top_base;
  logic [6:0]       new_top;
  logic             closes;

  assign in_stall     = q_status.full;
  assign accept       = in_valid && !in_stall;
  assign out_of_range = (fill_count_r >= POS_W'(GROUP_SIZE));
  assign pos          = out_of_range ? '0 : fill_count_r;
  assign top_base     = out_of_range ? '0 : top_bits_r;
  assign new_top      = top_base |
                        (((in_data.data_byte & TOP_BIT) != 8'h00) ? (7'd1 << pos) : 7'd0);
  assign closes       = (pos == POS_W'(GROUP_SIZE - 1)) || in_data.last_byte;

  always_comb begin
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (POS_W'(i) == pos) begin
        push_group.data[i] = in_data.data_byte[6:0] & LOW7_MASK;
      end else begin
        push_group.data[i] = store_r[i];
      end
    end
    push_group.top_bits = new_top;
    push_group.count    = pos + POS_W'(1);
    push_group.last     = in_data.last_byte;
  end

  assign push = accept && closes;

  always_comb begin
    store_nxt      = store_r;
    top_bits_nxt   = top_bits_r;
    fill_count_nxt = fill_count_r;
    if (accept) begin
      store_nxt[pos] = in_data.data_byte[6:0];
      if (closes) begin
        top_bits_nxt   = '0;
        fill_count_nxt = '0;
      end else begin
        top_bits_nxt   = new_top;
        fill_count_nxt = pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
    if (!rst_n) begin
      top_bits_r   <= '0;
      fill_count_r <= '0;
    end else begin
      top_bits_r   <= top_bits_nxt;
      fill_count_r <= fill_count_nxt;
    end
  end

endmodule

/* rtl/core/sme_queue.sv */
// ----------------------------------------------------------------------------
// sme_queue
// Two-entry queue of closed groups between front and back.
// ----------------------------------------------------------------------------
module sme_queue
  import sme_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  group_t        push_group,
  input  logic          pop,
  output group_t        head,
  output queue_status_t status
);

  group_t [1:0] entry_r;
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;

  assign head         = entry_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_group;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/core/sme_back.sv */
// ----------------------------------------------------------------------------
// sme_back
// Sends the header and data bytes of each queued group through an output
// register.
// ----------------------------------------------------------------------------
module sme_back
  import sme_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  group_t        head,
  input  queue_status_t q_status,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output out_item_t     out_data
);

  logic [POS_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             emit;
  logic             final_byte;
  logic [POS_W-1:0] sel;

  assign emit       = !q_status.empty && (!out_valid_r || !out_stall);
  assign final_byte = (idx_r != '0) && (idx_r == head.count);
  assign sel        = idx_r - POS_W'(1);
  assign pop        = emit && final_byte;

  always_comb begin
    if (idx_r == '0) begin
      out_data_nxt.out_byte    = head.top_bits;
      out_data_nxt.is_header   = 1'b1;
      out_data_nxt.run_last    = 1'b0;
      out_data_nxt.message_end = 1'b0;
    end else begin
      out_data_nxt.out_byte    = head.data[sel];
      out_data_nxt.is_header   = 1'b0;
      out_data_nxt.run_last    = final_byte;
      out_data_nxt.message_end = final_byte && head.last;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (emit) begin
      idx_nxt = final_byte ? '0 : idx_r + POS_W'(1);
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/sysex_msb_group_encoder_top.sv */
// ----------------------------------------------------------------------------
// sysex_msb_group_encoder_top
// Packs 8-bit message bytes into 7-bit sysex-safe bytes, msb-group scheme.
// ----------------------------------------------------------------------------
// header path: closing byte -> queue entry -> output register
// throughput: one input byte per cycle while the queue is not full, one output
//   byte per cycle from the back end while out_stall is low; a full group of
//   7 bytes gives 8 output bytes, so the single output byte port sets the pace
// reset: synchronous active-low, clears open group, queue and output valid
// ----------------------------------------------------------------------------
module sysex_msb_group_encoder_top
  import sme_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  queue_status_t q_status;
  logic          push;
  logic          pop;
  group_t        push_group;
  group_t        head;

  sme_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_status   (q_status),
    .push       (push),
    .push_group (push_group)
  );

  sme_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  sme_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/sysex_msb_group_encoder_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sysex_msb_group_encoder_checker
// Watches both channels of the msb-group encoder. Keeps its own copy of the
// open group, builds the header and data bytes for every accepted request
// and compares each accepted output byte field by field, in order.
// ----------------------------------------------------------------------------
module sysex_msb_group_encoder_checker
  import sme_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        checked_count
);

  localparam int REPORT_LIMIT = 10;

  out_item_t        packed_q[$];
  logic [6:0]       group_lo [GROUP_SIZE];
  logic [6:0]       top_acc;
  logic [POS_W-1:0] fill;

  task automatic pack_byte(input in_item_t req);
    int unsigned pos;
    int unsigned count;
    out_item_t   r;
    pos = 32'(fill);
    if (pos >= GROUP_SIZE) begin
      pos     = 0;
      top_acc = '0;
    end
    group_lo[pos] = req.data_byte[6:0];
    if (req.data_byte[7]) top_acc[pos] = 1'b1;
    count = pos + 1;
    if (count < GROUP_SIZE && !req.last_byte) begin
      fill = count[POS_W-1:0];
      return;
    end
    r.out_byte    = top_acc;
    r.is_header   = 1'b1;
    r.run_last    = 1'b0;
    r.message_end = 1'b0;
    packed_q.push_back(r);
    for (int i = 0; i < count; i++) begin
      r.out_byte    = group_lo[i];
      r.is_header   = 1'b0;
      r.run_last    = (i + 1 == count);
      r.message_end = (i + 1 == count) && req.last_byte;
      packed_q.push_back(r);
    end
    top_acc = '0;
    fill    = '0;
  endtask

  task automatic check_byte(input out_item_t got);
    out_item_t want;
    if (packed_q.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: unexpected output byte=%0h hdr=%0b rlast=%0b mend=%0b",
                 $realtime, got.out_byte, got.is_header, got.run_last,
                 got.message_end);
      return;
    end
    want = packed_q.pop_front();
    checked_count++;
    if (got.out_byte !== want.out_byte || got.is_header !== want.is_header ||
        got.run_last !== want.run_last || got.message_end !== want.message_end) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
        $display("%0t: mismatch exp byte=%0h hdr=%0b rlast=%0b mend=%0b",
                 $realtime, want.out_byte, want.is_header, want.run_last,
                 want.message_end);
        $display("    got byte=%0h hdr=%0b rlast=%0b mend=%0b",
                 got.out_byte, got.is_header, got.run_last, got.message_end);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      packed_q.delete();
      top_acc = '0;
      fill    = '0;
    end else begin
      if (in_valid && !in_stall) pack_byte(in_data);
      if (out_valid && !out_stall) check_byte(out_data);
    end
    pending = packed_q.size();
  end

endmodule

/* tb/sysex_msb_group_encoder_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sysex_msb_group_encoder_top_test
// Drives byte requests into the msb-group encoder: a directed set of edge
// values and group shapes, then random messages of many lengths, with random
// gaps on both sides (not in the last phase) and one long output hold-off.
// The checker does the prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module sysex_msb_group_encoder_top_test
  import sme_pkg::*;
();

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 12;
  localparam int DIRECTED_N   = 22;
  localparam int PHASE_A_N    = 200;
  localparam int PHASE_B_N    = 150;
  localparam int PHASE_C_N    = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count;
  int pending;
  int checked_count;
  int cycle_count;
  int sent_count;
  int message_count;
  int hold_req_cycles;
  bit hold_done;
  bit sender_gaps;
  bit receiver_gaps;

  // {data byte, last flag}
  logic [8:0] directed_reqs [DIRECTED_N] = '{
    {8'h00, 1'b1}, {8'hff, 1'b1}, {8'h80, 1'b1}, {8'h7f, 1'b1},
    {8'hff, 1'b0}, {8'h00, 1'b0}, {8'h80, 1'b0}, {8'h7f, 1'b0},
    {8'haa, 1'b0}, {8'h55, 1'b0}, {8'hff, 1'b0},
    {8'h3c, 1'b1},
    {8'h81, 1'b0}, {8'h7e, 1'b0}, {8'hc0, 1'b0}, {8'h01, 1'b0},
    {8'hfe, 1'b0}, {8'h40, 1'b0}, {8'h80, 1'b1},
    {8'h80, 1'b0}, {8'h01, 1'b0}, {8'hfe, 1'b1}
  };

  sysex_msb_group_encoder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sysex_msb_group_encoder_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // output side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req_cycles != 0 && !hold_done) begin
        out_stall <= 1'b1;
        repeat (hold_req_cycles) @(negedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_req(input in_item_t req);
    int gap;
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sent_count++;
    if (req.last_byte) message_count++;
  endtask

  task automatic random_traffic(input int n);
    int       stop_at;
    int       kind;
    int       len;
    in_item_t req;
    stop_at = sent_count + n;
    while (sent_count < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // noise: arbitrary last flags
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          req.data_byte = 8'($urandom());
          req.last_byte = ($urandom_range(0, 2) == 0);
          send_req(req);
        end
      end else begin
        if (kind <= 5) len = $urandom_range(1, 9);
        else if (kind <= 7) len = 7 * $urandom_range(1, 3);
        else len = $urandom_range(10, 30);
        for (int i = 0; i < len; i++) begin
          req.data_byte = 8'($urandom());
          req.last_byte = (i == len - 1);
          send_req(req);
        end
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    sent_count      = 0;
    message_count   = 0;
    hold_req_cycles = 0;
    sender_gaps     = 1'b0;
    receiver_gaps   = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    for (int i = 0; i < DIRECTED_N; i++) send_req(in_item_t'(directed_reqs[i]));

    random_traffic(PHASE_A_N);

    // long output hold-off while requests keep coming
    hold_req_cycles = HOLD_CYCLES;
    random_traffic(PHASE_B_N);

    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    random_traffic(PHASE_C_N);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d byte requests in %0d messages, checked %0d output bytes",
             sent_count, message_count, checked_count);
    $display("edge values, full and partial groups, random gaps, %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
